[hdl/bdpc_pkg.sv]
package bdpc_pkg;

    // threshold registers as written, in milliseconds
    localparam int THRESH_W = 22;
    // thresholds held in microseconds: 22-bit ms times 1000 fits in 32 bits
    localparam int THRESH_US_W = 32;
    localparam int US_PER_MS = 1000;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_THRESH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_THRESH = 2'd1;

    // reset values of the thresholds, in milliseconds
    localparam int LONG_RESET_MS = 1000;
    localparam int HOLD_RESET_MS = 5000;

    // event codes
    localparam int EV_W = 2;
    localparam logic [EV_W-1:0] EV_SHORT = 2'd0;
    localparam logic [EV_W-1:0] EV_LONG  = 2'd1;
    localparam logic [EV_W-1:0] EV_HOLD  = 2'd2;

    // one queued result word
    typedef struct packed {
        logic [EV_W-1:0] code;
        logic            last;
    } event_t;

endpackage

[hdl/button_debounce_press_classifier.sv]
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    raw_level, time_us
// out       output     out_valid / out_ready  event_code, last_event
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One poll tick is taken per cycle while the queue has room; it is held in
// the input register, then the debounce and classify logic updates the state.
// A tick gives zero, one or two events; they wait in a four-word queue and
// leave one word per cycle while out_ready is high. A tick is processed
// only while the queue has room for two words.
// Reset (rst_n low) clears the state, empties the queue and restores the
// thresholds to 1000 ms and 5000 ms; cfg_ready is always high.
module button_debounce_press_classifier
    import bdpc_pkg::*;
#(
    parameter int DEBOUNCE_SAMPLES = 3,
    parameter int TIME_WIDTH = 48
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   raw_level,
    input  logic [TIME_WIDTH-1:0]  time_us,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [EV_W-1:0]        event_code,
    output logic                   last_event,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [THRESH_W-1:0]    cfg_data
);

    localparam int CNT_W = $clog2(DEBOUNCE_SAMPLES + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

    // thresholds in microseconds
    logic [THRESH_US_W-1:0] long_us_reg;
    logic [THRESH_US_W-1:0] hold_us_reg;

    // input register
    logic                  s1_valid_reg;
    logic                  s1_raw_reg;
    logic [TIME_WIDTH-1:0] s1_time_reg;

    // classifier state
    logic                  sampled_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  deb_reg;
    logic [TIME_WIDTH-1:0] start_reg;
    logic                  long_sent_reg;
    logic                  hold_sent_reg;

    logic                  sampled_next;
    logic [CNT_W-1:0]      cnt_next;
    logic                  deb_next;
    logic [TIME_WIDTH-1:0] start_next;
    logic                  long_sent_next;
    logic                  hold_sent_next;

    // result queue
    event_t                fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [FCNT_W-1:0]     fcnt_reg;

    logic                  s1_fire;
    logic                  pop;
    logic                  ev_short;
    logic                  long_hit;
    logic                  hold_hit;
    logic [1:0]            push_n;
    event_t                ev0;
    event_t                ev1;
    logic                  pressed;
    logic                  deb_change;
    logic [TIME_WIDTH-1:0] elapsed;

    // handshakes
    assign s1_fire   = s1_valid_reg && (fcnt_reg <= FCNT_W'(FIFO_DEPTH - 2));
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign cfg_ready = 1'b1;
    assign out_valid = (fcnt_reg != '0);
    assign pop       = out_valid && out_ready;

    // configuration registers, converted to microseconds on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_us_reg <= THRESH_US_W'(LONG_RESET_MS * US_PER_MS);
            hold_us_reg <= THRESH_US_W'(HOLD_RESET_MS * US_PER_MS);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LONG_THRESH:
                begin
                    long_us_reg <= THRESH_US_W'(cfg_data) * THRESH_US_W'(US_PER_MS);
                end
                CFG_HOLD_THRESH:
                begin
                    hold_us_reg <= THRESH_US_W'(cfg_data) * THRESH_US_W'(US_PER_MS);
                end
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_raw_reg  <= raw_level;
            s1_time_reg <= time_us;
        end
    end

    // debounce and press classification
    always_comb
    begin
        pressed        = !s1_raw_reg;
        sampled_next   = sampled_reg;
        cnt_next       = cnt_reg;
        deb_next       = deb_reg;
        start_next     = start_reg;
        long_sent_next = long_sent_reg;
        hold_sent_next = hold_sent_reg;
        ev_short       = 1'b0;
        long_hit       = 1'b0;
        hold_hit       = 1'b0;

        // count equal samples, saturating
        if (pressed == sampled_reg)
        begin
            if (cnt_reg < CNT_W'(DEBOUNCE_SAMPLES))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else
        begin
            sampled_next = pressed;
            cnt_next     = CNT_W'(1);
        end

        // debounced edge
        deb_change = (cnt_next >= CNT_W'(DEBOUNCE_SAMPLES)) && (sampled_next != deb_reg);
        if (deb_change)
        begin
            deb_next = sampled_next;
            if (sampled_next)
            begin
                start_next     = s1_time_reg;
                long_sent_next = 1'b0;
                hold_sent_next = 1'b0;
            end
            else if (!long_sent_reg && !hold_sent_reg)
            begin
                ev_short = 1'b1;
            end
        end

        // held time against both thresholds
        elapsed = s1_time_reg - start_next;
        if (deb_next && !hold_sent_next)
        begin
            if (!long_sent_next && (elapsed >= TIME_WIDTH'(long_us_reg)))
            begin
                long_hit       = 1'b1;
                long_sent_next = 1'b1;
            end
            if (elapsed >= TIME_WIDTH'(hold_us_reg))
            begin
                hold_hit       = 1'b1;
                hold_sent_next = 1'b1;
            end
        end

        // order the words: long before hold
        push_n = 2'(ev_short) + 2'(long_hit) + 2'(hold_hit);
        if (long_hit)
        begin
            ev0.code = EV_LONG;
        end
        else if (ev_short)
        begin
            ev0.code = EV_SHORT;
        end
        else
        begin
            ev0.code = EV_HOLD;
        end
        ev0.last = (push_n == 2'd1);
        ev1.code = EV_HOLD;
        ev1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sampled_reg   <= 1'b0;
            cnt_reg       <= '0;
            deb_reg       <= 1'b0;
            start_reg     <= '0;
            long_sent_reg <= 1'b0;
            hold_sent_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            sampled_reg   <= sampled_next;
            cnt_reg       <= cnt_next;
            deb_reg       <= deb_next;
            start_reg     <= start_next;
            long_sent_reg <= long_sent_next;
            hold_sent_reg <= hold_sent_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (s1_fire && (push_n != 2'd0))
        begin
            fifo_mem_reg[wr_ptr_reg] <= ev0;
        end
        if (s1_fire && (push_n == 2'd2))
        begin
            fifo_mem_reg[wr_ptr_reg + 1'b1] <= ev1;
        end
    end

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fcnt_reg   <= '0;
        end
        else
        begin
            if (s1_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fcnt_reg <= fcnt_reg + (s1_fire ? FCNT_W'(push_n) : FCNT_W'(0))
                        - FCNT_W'(pop);
        end
    end

    assign event_code = fifo_mem_reg[rd_ptr_reg].code;
    assign last_event = fifo_mem_reg[rd_ptr_reg].last;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // a short press only comes with a debounced release
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && ev_short |-> !deb_next && !long_hit && !hold_hit)
        else $error("short press without release");

    // a long press marks itself sent for the rest of the press
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && long_hit |=> long_sent_reg && deb_reg)
        else $error("long press not recorded");

endmodule

[tb/sv/button_debounce_press_classifier_checker.sv]
`timescale 1ns / 1ps

module button_debounce_press_classifier_checker
    import bdpc_pkg::*;
#(
    parameter int DEBOUNCE_SAMPLES = 3,
    parameter int TIME_WIDTH = 48
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   raw_level,
    input  logic [TIME_WIDTH-1:0]  time_us,

    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [EV_W-1:0]        event_code,
    input  logic                   last_event,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [THRESH_W-1:0]    cfg_data,

    output int                     mismatches,
    output int                     pending
);

    // shadow thresholds in milliseconds
    logic [THRESH_W-1:0]   long_ms;
    logic [THRESH_W-1:0]   hold_ms;

    // shadow debounce and press state
    logic                  sampled_pressed;
    int                    equal_count;
    logic                  debounced_pressed;
    logic [TIME_WIDTH-1:0] press_start;
    logic                  long_sent;
    logic                  hold_sent;

    // events still owed by the block, oldest first
    event_t                expected_events[$];
    event_t                want;

    // debounce one poll tick and queue the events it should raise
    task automatic classify_tick(input logic level, input logic [TIME_WIDTH-1:0] now);
        logic                  pressed;
        logic [TIME_WIDTH-1:0] held_us;
        event_t                ev;
        event_t                raised[$];
        pressed = !level;

        // count equal samples, restart on a change of level
        if (pressed == sampled_pressed)
        begin
            if (equal_count < DEBOUNCE_SAMPLES)
                equal_count++;
        end
        else
        begin
            sampled_pressed = pressed;
            equal_count = 1;
        end

        // debounced edge: a press stamps the time, a release may be a short press
        if (equal_count >= DEBOUNCE_SAMPLES && sampled_pressed != debounced_pressed)
        begin
            debounced_pressed = sampled_pressed;
            if (debounced_pressed)
            begin
                press_start = now;
                long_sent = 1'b0;
                hold_sent = 1'b0;
            end
            else if (!long_sent && !hold_sent)
            begin
                ev.code = EV_SHORT;
                ev.last = 1'b0;
                raised.push_back(ev);
            end
        end

        // held time against both thresholds, long press first
        if (debounced_pressed && !hold_sent)
        begin
            held_us = now - press_start;
            if (!long_sent && 64'(held_us) >= 64'(long_ms) * 64'(US_PER_MS))
            begin
                long_sent = 1'b1;
                ev.code = EV_LONG;
                ev.last = 1'b0;
                raised.push_back(ev);
            end
            if (64'(held_us) >= 64'(hold_ms) * 64'(US_PER_MS))
            begin
                hold_sent = 1'b1;
                ev.code = EV_HOLD;
                ev.last = 1'b0;
                raised.push_back(ev);
            end
        end

        // the final event of the tick carries the last mark
        if (raised.size() > 0)
            raised[raised.size()-1].last = 1'b1;
        foreach (raised[i])
            expected_events.push_back(raised[i]);
    endtask

    // watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ms = THRESH_W'(LONG_RESET_MS);
            hold_ms = THRESH_W'(HOLD_RESET_MS);
            sampled_pressed = 1'b0;
            equal_count = 0;
            debounced_pressed = 1'b0;
            press_start = '0;
            long_sent = 1'b0;
            hold_sent = 1'b0;
            mismatches = 0;
            expected_events.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LONG_THRESH: long_ms = cfg_data;
                    CFG_HOLD_THRESH: hold_ms = cfg_data;
                    default: ;
                endcase
            end

            // event words leaving the block
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected event word: code %0d last %0b",
                                 event_code, last_event);
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (want.code !== event_code || want.last !== last_event)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"event word mismatch: expected code %0d last %0b,",
                                      " got code %0d last %0b"},
                                     want.code, want.last, event_code, last_event);
                    end
                end
            end

            // poll ticks entering the block
            if (in_valid && in_ready)
                classify_tick(raw_level, time_us);
        end
        pending = expected_events.size();
    end

endmodule

[tb/sv/button_debounce_press_classifier_tb.sv]
`timescale 1ns / 1ps

module button_debounce_press_classifier_tb
    import bdpc_pkg::*;
();

    localparam int TIME_W = 48;
    localparam int SAMPLES = 3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TICKS_PER_PHASE = 70;
    localparam int RANDOM_PHASES = 7;
    localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   raw_level;
    logic [TIME_W-1:0]      time_us;
    logic                   out_valid;
    logic                   out_ready;
    logic [EV_W-1:0]        event_code;
    logic                   last_event;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [THRESH_W-1:0]    cfg_data;

    int                     mismatches;
    int                     pending;
    int                     cycle_count = 0;
    int                     sender_idle_pct;
    int                     recv_idle_pct;
    int                     phase_ticks;
    int unsigned            step_max;
    logic [TIME_W-1:0]      now_us;
    logic [THRESH_W-1:0]    long_set;
    logic [THRESH_W-1:0]    hold_set;
    logic [63:0]            span_us;

    button_debounce_press_classifier #(
        .DEBOUNCE_SAMPLES (SAMPLES),
        .TIME_WIDTH       (TIME_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_level  (raw_level),
        .time_us    (time_us),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .last_event (last_event),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    button_debounce_press_classifier_checker #(
        .DEBOUNCE_SAMPLES (SAMPLES),
        .TIME_WIDTH       (TIME_W)
    ) event_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_level  (raw_level),
        .time_us    (time_us),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_code (event_code),
        .last_event (last_event),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // receiver stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // offer one tick word, with random gaps before it; returns at a falling edge
    task automatic poll(input logic level, input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        raw_level <= level;
        time_us <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        phase_ticks++;
    endtask

    // timestamp for the next tick: mostly a forward step, now and then a jump anywhere
    function automatic logic [TIME_W-1:0] next_time();
        if ($urandom_range(99) < 3)
            now_us = {16'($urandom), $urandom};
        else
            now_us = now_us + TIME_W'($urandom_range(0, step_max));
        return now_us;
    endfunction

    // hold off until the block has nothing left to give
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // one register write word; valid is left high for the caller to lower
    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [THRESH_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // both thresholds, block idle
    task automatic set_thresholds(input logic [THRESH_W-1:0] long_val,
                                  input logic [THRESH_W-1:0] hold_val);
        write_cfg(CFG_LONG_THRESH, long_val);
        write_cfg(CFG_HOLD_THRESH, hold_val);
        cfg_valid <= 1'b0;
        // time steps scaled so a press of a dozen ticks reaches the larger threshold
        span_us = 64'(long_val > hold_val ? long_val : hold_val) * 64'(US_PER_MS);
        step_max = 32'(span_us / 3) + 2000;
    endtask

    // bouncy press, hold, bouncy release; short runs make broken sequences
    task automatic press_episode();
        int bounces;
        bounces = $urandom_range(0, 3);
        for (int i = 0; i < bounces; i++)
            poll(i[0], next_time());
        repeat ($urandom_range(1, 14)) poll(1'b0, next_time());
        bounces = $urandom_range(0, 3);
        for (int i = 0; i < bounces; i++)
            poll(!i[0], next_time());
        repeat ($urandom_range(1, 6)) poll(1'b1, next_time());
        // stray noise between presses
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 5)) poll(1'($urandom_range(1)), next_time());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        raw_level = 1'b1;
        time_us = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LONG_THRESH;
        cfg_data = '0;
        sender_idle_pct = 23;
        recv_idle_pct = 69;
        phase_ticks = 0;
        now_us = '0;
        step_max = 2000;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // released idle, then a bouncy press settling on the third equal sample
        poll(1'b1, 48'd0);
        poll(1'b0, 48'd10);
        poll(1'b1, 48'd20);
        poll(1'b0, 48'd30);
        poll(1'b0, 48'd40);
        poll(1'b0, 48'd50);
        // quick release gives a short press
        poll(1'b1, 48'd60);
        poll(1'b1, 48'd70);
        poll(1'b1, 48'd80);
        // reset thresholds: one below the long boundary, then exactly on it
        poll(1'b0, 48'd1000);
        poll(1'b0, 48'd1001);
        poll(1'b0, 48'd1002);
        poll(1'b0, 48'd1001001);
        poll(1'b0, 48'd1001002);
        // time running backwards reads as a very long hold
        poll(1'b0, 48'd5);
        // release after hold events: no short press
        poll(1'b1, 48'd10);
        poll(1'b1, 48'd20);
        poll(1'b1, 48'd30);

        // zero thresholds at the top of the time range: both events on the press tick
        wait_idle();
        set_thresholds('0, '0);
        poll(1'b0, 48'hFFFF_FFFF_FFFD);
        poll(1'b0, 48'hFFFF_FFFF_FFFE);
        poll(1'b0, 48'hFFFF_FFFF_FFFF);
        poll(1'b1, 48'h0);
        poll(1'b1, 48'h1);
        poll(1'b1, 48'h2);

        // random phases over a spread of threshold settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    long_set = THRESH_W'(LONG_RESET_MS);
                    hold_set = THRESH_W'(HOLD_RESET_MS);
                end
                1:
                begin
                    long_set = '0;
                    hold_set = '0;
                end
                2:
                begin
                    long_set = THRESH_MAX;
                    hold_set = THRESH_MAX;
                end
                3:
                begin
                    long_set = THRESH_MAX;
                    hold_set = THRESH_W'($urandom_range(1, 3000));
                end
                4:
                begin
                    long_set = THRESH_W'($urandom);
                    hold_set = THRESH_W'($urandom);
                end
                5:
                begin
                    long_set = THRESH_W'($urandom_range(1, 2000));
                    hold_set = THRESH_W'($urandom_range(1, 4000));
                end
                default:
                begin
                    long_set = THRESH_W'($urandom_range(0, 1500));
                    hold_set = '0;
                end
            endcase
            // idling: sender light then heavy, receiver heavy then light, then none at all
            if (p < 3)
            begin
                sender_idle_pct = 23;
                recv_idle_pct = 69;
            end
            else if (p < 5)
            begin
                sender_idle_pct = 69;
                recv_idle_pct = 23;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            set_thresholds(long_set, hold_set);
            phase_ticks = 0;
            while (phase_ticks < TICKS_PER_PHASE)
                press_episode();
        end

        // drain and verdict
        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
